@@ hdl/mi3_pkg.sv @@
package mi3_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int ENTRY_W = 16;
  localparam int PROD_W  = 32;
  localparam int COF_W   = 32;
  localparam int CMAG_W  = 31;
  localparam int DPROD_W = 48;
  localparam int DET_W   = 49;
  localparam int DMAG_W  = 48;
  localparam int INV_W   = 48;
  localparam int N_ELEM  = 9;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [COF_W-1:0]   cof_t;
  typedef logic signed [DET_W-1:0]   det_t;
  typedef logic signed [INV_W-1:0]   inv_t;

endpackage

@@ hdl/mi3_front.sv @@
module mi3_front
  import mi3_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  entry_t entry_i [N_ELEM],
  output logic   valid_o,
  output cof_t   cof_o [N_ELEM],
  output det_t   det_o
);

  logic                        v_q [5];
  entry_t                      m_q [N_ELEM];
  logic signed [PROD_W-1:0]    pa_q [N_ELEM];
  logic signed [PROD_W-1:0]    pb_q [N_ELEM];
  cof_t                        cof_q [N_ELEM];
  cof_t                        cof_d1_q [N_ELEM];
  cof_t                        cof_d2_q [N_ELEM];
  entry_t                      m0_d1_q [3];
  entry_t                      m0_d2_q [3];
  logic signed [DPROD_W-1:0]   dp_q [3];
  det_t                        det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 1; i < 5; i++) v_q[i] <= v_q[i-1];
    end
  end

  // Cofactor (rr,cc) is the minor over the cyclic successors of row rr and column cc.
  for (genvar k = 0; k < N_ELEM; k++) begin : g_cof
    localparam int RR = k / 3;
    localparam int CC = k % 3;
    localparam int R1 = (RR + 1) % 3;
    localparam int R2 = (RR + 2) % 3;
    localparam int C1 = (CC + 1) % 3;
    localparam int C2 = (CC + 2) % 3;
    always_ff @(posedge clk_i) begin
      pa_q[k]     <= m_q[R1*3+C1] * m_q[R2*3+C2];
      pb_q[k]     <= m_q[R1*3+C2] * m_q[R2*3+C1];
      cof_q[k]    <= pa_q[k] - pb_q[k];
      cof_d1_q[k] <= cof_q[k];
      cof_d2_q[k] <= cof_d1_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N_ELEM; i++) m_q[i] <= entry_i[i];
    for (int c = 0; c < 3; c++) begin
      m0_d1_q[c] <= m_q[c];
      m0_d2_q[c] <= m0_d1_q[c];
      dp_q[c]    <= m0_d2_q[c] * cof_q[c];
    end
    det_q <= DET_W'(dp_q[0]) + DET_W'(dp_q[1]) + DET_W'(dp_q[2]);
  end

  assign valid_o = v_q[4];
  assign det_o   = det_q;
  always_comb begin
    for (int i = 0; i < N_ELEM; i++) cof_o[i] = cof_d2_q[i];
  end

endmodule

@@ hdl/mi3_div_lane.sv @@
module mi3_div_lane
  import mi3_pkg::*;
#(
  parameter int FracBits = FRAC_BITS_DEF,
  localparam int NB = CMAG_W + FracBits
)(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  cof_t          cof_i,
  input  det_t          det_i,
  output logic          valid_o,
  output logic [NB-1:0] quo_o,
  output logic          neg_o
);

  logic              v_q   [NB+1];
  logic [DMAG_W-1:0] rem_q [NB+1];
  logic [NB-1:0]     nq_q  [NB+1];
  logic [DMAG_W-1:0] d_q   [NB+1];
  logic              neg_q [NB+1];

  cof_t cmag;
  det_t dmag;

  assign cmag = cof_i[COF_W-1] ? -cof_i : cof_i;
  assign dmag = det_i[DET_W-1] ? -det_i : det_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NB; s++) v_q[s] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int s = 1; s <= NB; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    nq_q[0]  <= NB'(cmag[CMAG_W-1:0]) << FracBits;
    d_q[0]   <= dmag[DMAG_W-1:0];
    neg_q[0] <= cof_i[COF_W-1] ^ det_i[DET_W-1];
  end

  // One quotient bit per stage; the dividend shifts out at the top as quotient bits enter.
  for (genvar s = 0; s < NB; s++) begin : g_stage
    logic [DMAG_W:0] rem_t;
    logic [DMAG_W:0] diff;
    logic            ge;
    assign rem_t = {rem_q[s], nq_q[s][NB-1]};
    assign diff  = rem_t - {1'b0, d_q[s]};
    assign ge    = rem_t >= {1'b0, d_q[s]};
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= ge ? diff[DMAG_W-1:0] : rem_t[DMAG_W-1:0];
      nq_q[s+1]  <= {nq_q[s][NB-2:0], ge};
      d_q[s+1]   <= d_q[s];
      neg_q[s+1] <= neg_q[s];
    end
  end

  assign valid_o = v_q[NB];
  assign quo_o   = nq_q[NB];
  assign neg_o   = neg_q[NB];

endmodule

@@ hdl/mi3_merge.sv @@
module mi3_merge
  import mi3_pkg::*;
#(
  parameter int FracBits = FRAC_BITS_DEF,
  localparam int NB = CMAG_W + FracBits,
  localparam int QX_W = NB + INV_W
)(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NB-1:0] quo_i [N_ELEM],
  input  logic          neg_i [N_ELEM],
  input  det_t          det_i,
  output logic          done_o,
  output inv_t          inv_o [N_ELEM],
  output det_t          det_o,
  output logic          singular_o
);

  localparam logic [QX_W-1:0] POS_LIM = QX_W'({1'b0, {(INV_W-1){1'b1}}});
  localparam logic [QX_W-1:0] NEG_LIM = QX_W'({1'b1, {(INV_W-1){1'b0}}});

  logic done_q;
  logic sing;
  inv_t inv_d [N_ELEM];
  inv_t inv_q [N_ELEM];
  det_t det_q;
  logic sing_q;

  assign sing = (det_i == '0);

  always_comb begin
    logic [QX_W-1:0] qx;
    for (int i = 0; i < N_ELEM; i++) begin
      qx = QX_W'(quo_i[i]);
      if (sing) begin
        inv_d[i] = '0;
      end else if (neg_i[i]) begin
        inv_d[i] = (qx > NEG_LIM) ? inv_t'(NEG_LIM[INV_W-1:0]) : -inv_t'(qx[INV_W-1:0]);
      end else begin
        inv_d[i] = (qx > POS_LIM) ? inv_t'(POS_LIM[INV_W-1:0]) : inv_t'(qx[INV_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N_ELEM; i++) inv_q[i] <= inv_d[i];
    det_q  <= det_i;
    sing_q <= sing;
  end

  assign done_o     = done_q;
  assign det_o      = det_q;
  assign singular_o = sing_q;
  always_comb begin
    for (int i = 0; i < N_ELEM; i++) inv_o[i] = inv_q[i];
  end

endmodule

@@ hdl/matrix_inverse_3x3_core.sv @@
// 3x3 integer matrix inverse by the adjugate.
// Drive the nine signed 16-bit entries with start high; busy stays low, so
// a new item is taken on every clock edge at which start is high.
// Each item returns exactly one result on the inv_*, determinant_o and
// singular_o ports, shown for one cycle with done_o high. The receiver
// cannot hold results off, and none is needed: there is no stall path.
// Throughput is one item per cycle. The pipeline is built around the nine
// pipelined restoring dividers, one per inverse entry, each resolving one
// quotient bit per stage over 31 + FracBits stages; the cofactor and
// determinant front end adds five stages, divider setup and the output
// merge one each.
// Entries are the transposed cofactor scaled by 2^FracBits over the
// determinant, truncated toward zero and saturated to 48 bits. A zero
// determinant raises singular_o and forces all entries to zero.
// Reset empties the pipeline; results in flight are dropped.
module matrix_inverse_3x3_core
  import mi3_pkg::*;
#(
  parameter int FracBits = FRAC_BITS_DEF,
  localparam int NB = CMAG_W + FracBits
)(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  output logic   busy,
  input  entry_t entry_r0c0_i,
  input  entry_t entry_r0c1_i,
  input  entry_t entry_r0c2_i,
  input  entry_t entry_r1c0_i,
  input  entry_t entry_r1c1_i,
  input  entry_t entry_r1c2_i,
  input  entry_t entry_r2c0_i,
  input  entry_t entry_r2c1_i,
  input  entry_t entry_r2c2_i,
  output logic   done_o,
  output inv_t   inv_r0c0_o,
  output inv_t   inv_r0c1_o,
  output inv_t   inv_r0c2_o,
  output inv_t   inv_r1c0_o,
  output inv_t   inv_r1c1_o,
  output inv_t   inv_r1c2_o,
  output inv_t   inv_r2c0_o,
  output inv_t   inv_r2c1_o,
  output inv_t   inv_r2c2_o,
  output det_t   determinant_o,
  output logic   singular_o
);

  entry_t        entry [N_ELEM];
  logic          fr_valid;
  cof_t          cof [N_ELEM];
  det_t          det;
  logic          ln_valid [N_ELEM];
  logic [NB-1:0] quo [N_ELEM];
  logic          neg [N_ELEM];
  inv_t          inv [N_ELEM];
  det_t          det_dly_q [NB+1];

  assign busy = 1'b0;

  assign entry[0] = entry_r0c0_i;
  assign entry[1] = entry_r0c1_i;
  assign entry[2] = entry_r0c2_i;
  assign entry[3] = entry_r1c0_i;
  assign entry[4] = entry_r1c1_i;
  assign entry[5] = entry_r1c2_i;
  assign entry[6] = entry_r2c0_i;
  assign entry[7] = entry_r2c1_i;
  assign entry[8] = entry_r2c2_i;

  mi3_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .entry_i (entry),
    .valid_o (fr_valid),
    .cof_o   (cof),
    .det_o   (det)
  );

  // Inverse entry (r,c) divides the cofactor of matrix entry (c,r).
  for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
    localparam int R = k / 3;
    localparam int C = k % 3;
    mi3_div_lane #(.FracBits(FracBits)) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (fr_valid),
      .cof_i   (cof[C*3+R]),
      .det_i   (det),
      .valid_o (ln_valid[k]),
      .quo_o   (quo[k]),
      .neg_o   (neg[k])
    );
  end

  // The determinant rides alongside the dividers to meet its entries.
  always_ff @(posedge clk_i) begin
    det_dly_q[0] <= det;
    for (int s = 1; s <= NB; s++) det_dly_q[s] <= det_dly_q[s-1];
  end

  mi3_merge #(.FracBits(FracBits)) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (ln_valid[0]),
    .quo_i      (quo),
    .neg_i      (neg),
    .det_i      (det_dly_q[NB]),
    .done_o     (done_o),
    .inv_o      (inv),
    .det_o      (determinant_o),
    .singular_o (singular_o)
  );

  assign inv_r0c0_o = inv[0];
  assign inv_r0c1_o = inv[1];
  assign inv_r0c2_o = inv[2];
  assign inv_r1c0_o = inv[3];
  assign inv_r1c1_o = inv[4];
  assign inv_r1c2_o = inv[5];
  assign inv_r2c0_o = inv[6];
  assign inv_r2c1_o = inv[7];
  assign inv_r2c2_o = inv[8];

endmodule

@@ hdl/mi3_checker.sv @@
module mi3_checker
  import mi3_pkg::*;
#(
  parameter int FracBits = FRAC_BITS_DEF,
  localparam int Lat = 7 + CMAG_W + FracBits
)(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input inv_t inv_r0c0_o,
  input inv_t inv_r2c2_o,
  input det_t determinant_o,
  input logic singular_o
);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Lat))
    else $error("result without a matching item");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && singular_o) |->
      (determinant_o == '0 && inv_r0c0_o == '0 && inv_r2c2_o == '0))
    else $error("singular result carries nonzero fields");

  a_regular_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !singular_o) |-> (determinant_o != '0))
    else $error("zero determinant not flagged singular");

endmodule

bind matrix_inverse_3x3_core mi3_checker #(.FracBits(FracBits)) u_mi3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .inv_r0c0_o    (inv_r0c0_o),
  .inv_r2c2_o    (inv_r2c2_o),
  .determinant_o (determinant_o),
  .singular_o    (singular_o)
);

@@ sim/matrix_inverse_3x3_core_test.sv @@
module matrix_inverse_3x3_core_test;
  import mi3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 38 + FRAC;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint INV_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INV_LO = -INV_HI - 1;

  typedef struct {
    inv_t inv[N_ELEM];
    det_t det;
    logic sing;
  } inverse_t;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  entry_t ent[N_ELEM];
  logic   done_o;
  inv_t   inv_o[N_ELEM];
  det_t   determinant_o;
  logic   singular_o;

  inverse_t pending_inverses[$];
  int errors;
  int items_sent;
  int results_seen;
  int singular_seen;
  longint cycles;
  bit idle_enabled;

  matrix_inverse_3x3_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .entry_r0c0_i(ent[0]),
    .entry_r0c1_i(ent[1]),
    .entry_r0c2_i(ent[2]),
    .entry_r1c0_i(ent[3]),
    .entry_r1c1_i(ent[4]),
    .entry_r1c2_i(ent[5]),
    .entry_r2c0_i(ent[6]),
    .entry_r2c1_i(ent[7]),
    .entry_r2c2_i(ent[8]),
    .done_o(done_o),
    .inv_r0c0_o(inv_o[0]),
    .inv_r0c1_o(inv_o[1]),
    .inv_r0c2_o(inv_o[2]),
    .inv_r1c0_o(inv_o[3]),
    .inv_r1c1_o(inv_o[4]),
    .inv_r1c2_o(inv_o[5]),
    .inv_r2c0_o(inv_o[6]),
    .inv_r2c1_o(inv_o[7]),
    .inv_r2c2_o(inv_o[8]),
    .determinant_o(determinant_o),
    .singular_o(singular_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Cofactor of entry (rr, cc) in the cyclic form, so no sign is needed.
  function automatic longint cofactor_of(input longint m[3][3], input int rr, input int cc);
    int r1, r2, c1, c2;
    r1 = (rr + 1) % 3;
    r2 = (rr + 2) % 3;
    c1 = (cc + 1) % 3;
    c2 = (cc + 2) % 3;
    return m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1];
  endfunction

  function automatic inverse_t compute_inverse(input entry_t e[N_ELEM]);
    inverse_t res;
    longint m[3][3];
    longint det, num, q;
    det = 0;
    for (int i = 0; i < N_ELEM; i++) m[i / 3][i % 3] = longint'(e[i]);
    for (int c = 0; c < 3; c++) det += m[0][c] * cofactor_of(m, 0, c);
    res.det = det_t'(det);
    res.sing = (det == 0);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (det == 0) begin
          q = 0;
        end else begin
          num = cofactor_of(m, c, r) * (longint'(1) << FRAC);
          q = num / det;
          if (q > INV_HI) q = INV_HI;
          if (q < INV_LO) q = INV_LO;
        end
        res.inv[r * 3 + c] = inv_t'(q);
      end
    end
    return res;
  endfunction

  // Drives one matrix from a falling edge until the block takes it.
  // start stays high afterwards, so the next item can follow with no gap.
  task automatic send_matrix(input entry_t e[N_ELEM]);
    bit taken;
    if (idle_enabled) begin
      while ($urandom_range(99) < 37) begin
        @(negedge clk_i);
        start = 1'b0;
        for (int i = 0; i < N_ELEM; i++) ent[i] = entry_t'($urandom);
      end
    end
    @(negedge clk_i);
    ent = e;
    start = 1'b1;
    taken = 0;
    while (!taken) begin
      // busy only moves on a rising edge, so its value here holds at the next one.
      if (!busy) begin
        pending_inverses.push_back(compute_inverse(e));
        items_sent++;
        taken = 1;
      end
      @(posedge clk_i);
      if (!taken) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_inverses.size() != 0) @(negedge clk_i);
  endtask

  function automatic entry_t pick_entry(input int mode);
    case (mode)
      0: return entry_t'($urandom);
      1: return entry_t'($urandom_range(8) - 4);
      default: begin
        case ($urandom_range(3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return entry_t'($urandom_range(2) - 1);
          default: return entry_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic test_directed();
    entry_t e[N_ELEM];
    e = '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
    send_matrix(e);
    e = '{default: 16'sd0};
    send_matrix(e);
    e = '{default: 16'sh7FFF};
    send_matrix(e);
    e = '{default: 16'sh8000};
    send_matrix(e);
    e = '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 16'sd9};
    send_matrix(e);
    e = '{16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd7};
    send_matrix(e);
    e = '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFE, 16'sd0, 16'sd1, 16'sd1};
    send_matrix(e);
    e = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
    send_matrix(e);
    e = '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000,
          16'sh8000, 16'sh8000, 16'sh7FFF};
    send_matrix(e);
    e = '{-16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1};
    send_matrix(e);
    e = '{16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0};
    send_matrix(e);
    e = '{16'sd3, 16'sd1, 16'sd0, 16'sd5, 16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
    send_matrix(e);
  endtask

  task automatic test_random(input int count);
    entry_t e[N_ELEM];
    int mode;
    for (int n = 0; n < count; n++) begin
      // Back-to-back stretch in the middle of the run.
      idle_enabled = !(n >= count / 3 && n < count / 3 + 200);
      mode = $urandom_range(2);
      for (int i = 0; i < N_ELEM; i++) e[i] = pick_entry(mode);
      // Some matrices get a repeated or scaled row so singular cases are common.
      if ($urandom_range(9) == 0) begin
        for (int c = 0; c < 3; c++) e[6 + c] = e[c];
      end else if ($urandom_range(9) == 0) begin
        for (int c = 0; c < 3; c++) e[3 + c] = entry_t'(e[c] * -1);
      end
      send_matrix(e);
    end
    idle_enabled = 1;
  endtask

  task automatic test_drain_pause();
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    inverse_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (singular_o) singular_seen++;
      if (pending_inverses.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, det %0d", $time, determinant_o);
      end else begin
        want = pending_inverses.pop_front();
        for (int i = 0; i < N_ELEM; i++) begin
          if (inv_o[i] !== want.inv[i]) begin
            errors++;
            $display("%0t: inverse entry %0d expected %0d actual %0d", $time, i,
                     want.inv[i], inv_o[i]);
          end
        end
        if (determinant_o !== want.det) begin
          errors++;
          $display("%0t: determinant expected %0d actual %0d", $time, want.det,
                   determinant_o);
        end
        if (singular_o !== want.sing) begin
          errors++;
          $display("%0t: singular expected %0b actual %0b", $time, want.sing, singular_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    singular_seen = 0;
    cycles = 0;
    idle_enabled = 1;
    start = 1'b0;
    ent = '{default: 16'sd0};
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_drain_pause();
    test_random(850);
    test_drain_pause();
    test_random(850);
    wait_drained();
    repeat (LATENCY + 10) @(negedge clk_i);
    $display("Sent %0d matrices and checked %0d inverses, %0d of them singular,",
             items_sent, results_seen, singular_seen);
    $display("with random idle gaps, a back-to-back stretch and full drains.");
    if (errors == 0 && pending_inverses.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_inverses.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
